/* design/coapme_pkg.sv */
// Shared types, codes and helpers for the CoAP message encoder.
package coapme_pkg;

    localparam int MAX_TOKEN_LEN = 8;
    localparam int RUN_BYTES     = 5;
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = $clog2(Q_DEPTH);

    localparam logic [15:0] MAX_LEN_RESET = 16'd1152;
    localparam logic [15:0] HDR_BYTES     = 16'd4;
    localparam logic [7:0]  END_MARK      = 8'hFF;
    localparam logic [1:0]  COAP_VERSION  = 2'd1;

    localparam logic [15:0] EXT1_BASE = 16'd13;
    localparam logic [15:0] EXT2_BASE = 16'd269;
    localparam logic [3:0]  NIB_EXT1  = 4'd13;
    localparam logic [3:0]  NIB_EXT2  = 4'd14;

    typedef enum logic [2:0] {
        OP_BEGIN   = 3'd0,
        OP_TOKEN   = 3'd1,
        OP_OPTION  = 3'd2,
        OP_VALUE   = 3'd3,
        OP_PAYLOAD = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TOKEN = 2'd1,
        ST_ORDER = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // One request's worth of output bytes
    typedef struct packed {
        logic [RUN_BYTES-1:0][7:0] bytes;
        logic [2:0]                last_idx;
        status_t                   status;
        logic [15:0]               base;
    } run_t;

    typedef struct packed {
        logic [3:0] nib;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [1:0] n;
    } ext_t;

    function automatic ext_t ext_code(logic [15:0] v);
        ext_t        e;
        logic [15:0] w;
        e = '0;
        w = v - EXT2_BASE;
        if (v < EXT1_BASE) begin
            e.nib = v[3:0];
        end
        else if (v < EXT2_BASE) begin
            e.nib = NIB_EXT1;
            e.b0  = 8'(v - EXT1_BASE);
            e.n   = 2'd1;
        end
        else begin
            e.nib = NIB_EXT2;
            e.b0  = w[15:8];
            e.b1  = w[7:0];
            e.n   = 2'd2;
        end
        return e;
    endfunction

endpackage

/* design/coap_message_encoder.sv */
// Top level of the CoAP message encoder.
// Requests are taken one per cycle while the four-entry run queue has room; each
// request becomes a run of zero to five bytes (header: four, option header: one to
// five, first payload byte: two with the end-of-options marker, other data: one,
// error: a single zero byte, undefined opcodes: none). The back end sends one
// byte per cycle while each byte is popped, which is the sustained throughput. The
// first byte passes the run queue and the output register before the result ports.
// Errors stay sticky until the next begin request; the user must write max_packet_len
// through cfg_we/cfg_wdata only while the block is idle; nothing enforces this.
module coap_message_encoder
    import coapme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  opcode,
    input  logic [1:0]  msg_type,
    input  logic [3:0]  token_length,
    input  logic [7:0]  msg_code,
    input  logic [15:0] message_id,
    input  logic [15:0] option_number,
    input  logic [15:0] option_length,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic [1:0]  status,
    output logic [15:0] packet_length
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    run_t q_wr_run;
    run_t q_rd_run;

    coapme_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .msg_type      (msg_type),
        .token_length  (token_length),
        .msg_code      (msg_code),
        .message_id    (message_id),
        .option_number (option_number),
        .option_length (option_length),
        .data_byte     (data_byte),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_run         (q_wr_run)
    );

    coapme_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_run   (q_wr_run),
        .wr_full  (q_full),
        .rd_en    (q_pop),
        .rd_run   (q_rd_run),
        .rd_valid (q_valid)
    );

    coapme_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_run         (q_rd_run),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .status        (status),
        .packet_length (packet_length)
    );

endmodule

/* design/coapme_front.sv */
// Front end: takes requests, tracks message state and builds byte runs.
module coapme_front
    import coapme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  opcode,
    input  logic [1:0]  msg_type,
    input  logic [3:0]  token_length,
    input  logic [7:0]  msg_code,
    input  logic [15:0] message_id,
    input  logic [15:0] option_number,
    input  logic [15:0] option_length,
    input  logic [7:0]  data_byte,
    input  logic        q_full,
    output logic        q_push,
    output run_t        q_run
);

    logic [15:0] max_len_reg;
    logic [15:0] prev_opt_reg, prev_opt_next;
    logic [15:0] emitted_reg, emitted_next;
    logic        started_reg, started_next;
    status_t     err_reg, err_next;

    logic        accept;
    logic        emit;
    run_t        run;
    ext_t        dext, lext;
    logic [15:0] delta;
    logic [2:0]  n;
    logic        fits;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept && emit;
    assign q_run  = run;

    assign delta = option_number - prev_opt_reg;
    assign dext  = ext_code(delta);
    assign lext  = ext_code(option_length);

    always_comb
    begin
        prev_opt_next = prev_opt_reg;
        emitted_next  = emitted_reg;
        started_next  = started_reg;
        err_next      = err_reg;
        emit          = 1'b1;
        run           = '0;
        run.base      = emitted_reg;
        n             = 3'd1;
        fits          = 1'b0;
        unique case (op_t'(opcode))
            OP_BEGIN:
            begin
                prev_opt_next = '0;
                started_next  = 1'b0;
                run.base      = '0;
                if (max_len_reg < HDR_BYTES) begin
                    err_next   = ST_FULL;
                    run.status = ST_FULL;
                    emitted_next = '0;
                end
                else if (token_length > 4'(MAX_TOKEN_LEN)) begin
                    err_next   = ST_TOKEN;
                    run.status = ST_TOKEN;
                    emitted_next = '0;
                end
                else begin
                    err_next     = ST_OK;
                    emitted_next = HDR_BYTES;
                    run.bytes[0] = {COAP_VERSION, msg_type, token_length};
                    run.bytes[1] = msg_code;
                    run.bytes[2] = message_id[15:8];
                    run.bytes[3] = message_id[7:0];
                    run.last_idx = 3'd3;
                end
            end
            OP_OPTION:
            begin
                n = 3'd1 + {1'b0, dext.n} + {1'b0, lext.n};
                fits = ({1'b0, emitted_reg} + {14'd0, n}) <= {1'b0, max_len_reg};
                run.bytes[0] = {dext.nib, lext.nib};
                unique case (dext.n)
                    2'd0:
                    begin
                        run.bytes[1] = lext.b0;
                        run.bytes[2] = lext.b1;
                    end
                    2'd1:
                    begin
                        run.bytes[1] = dext.b0;
                        run.bytes[2] = lext.b0;
                        run.bytes[3] = lext.b1;
                    end
                    default:
                    begin
                        run.bytes[1] = dext.b0;
                        run.bytes[2] = dext.b1;
                        run.bytes[3] = lext.b0;
                        run.bytes[4] = lext.b1;
                    end
                endcase
                run.last_idx = n - 3'd1;
                if (err_reg != ST_OK) begin
                    run.bytes  = '0;
                    run.last_idx = '0;
                    run.status = err_reg;
                end
                else if (started_reg || option_number < prev_opt_reg) begin
                    run.bytes  = '0;
                    run.last_idx = '0;
                    run.status = ST_ORDER;
                    err_next   = ST_ORDER;
                end
                else if (!fits) begin
                    run.bytes  = '0;
                    run.last_idx = '0;
                    run.status = ST_FULL;
                    err_next   = ST_FULL;
                end
                else begin
                    prev_opt_next = option_number;
                    emitted_next  = emitted_reg + 16'(n);
                end
            end
            OP_TOKEN, OP_VALUE, OP_PAYLOAD:
            begin
                if (op_t'(opcode) == OP_PAYLOAD && !started_reg) begin
                    n            = 3'd2;
                    run.bytes[0] = END_MARK;
                    run.bytes[1] = data_byte;
                end
                else begin
                    run.bytes[0] = data_byte;
                end
                fits = ({1'b0, emitted_reg} + {14'd0, n}) <= {1'b0, max_len_reg};
                run.last_idx = n - 3'd1;
                if (err_reg != ST_OK) begin
                    run.bytes  = '0;
                    run.last_idx = '0;
                    run.status = err_reg;
                end
                else if (!fits) begin
                    run.bytes  = '0;
                    run.last_idx = '0;
                    run.status = ST_FULL;
                    err_next   = ST_FULL;
                end
                else begin
                    emitted_next = emitted_reg + 16'(n);
                    if (op_t'(opcode) == OP_PAYLOAD) begin
                        started_next = 1'b1;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_len_reg  <= MAX_LEN_RESET;
            prev_opt_reg <= '0;
            emitted_reg  <= '0;
            started_reg  <= 1'b0;
            err_reg      <= ST_OK;
        end
        else begin
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            if (accept) begin
                prev_opt_reg <= prev_opt_next;
                emitted_reg  <= emitted_next;
                started_reg  <= started_next;
                err_reg      <= err_next;
            end
        end
    end

endmodule

/* design/coapme_fifo.sv */
// Short run queue between the front and back ends.
module coapme_fifo
    import coapme_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  run_t wr_run,
    output logic wr_full,
    input  logic rd_en,
    output run_t rd_run,
    output logic rd_valid
);

    run_t              mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW:0]     count_reg;

    assign wr_full  = count_reg == (Q_AW+1)'(Q_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_run   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* design/coapme_back.sv */
// Back end: walks each queued run and presents one byte per cycle while the consumer pops.
module coapme_back
    import coapme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  run_t        q_run,
    input  logic        q_valid,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic [1:0]  status,
    output logic [15:0] packet_length
);

    logic [2:0]  idx_reg;
    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    status_t     status_reg;
    logic [15:0] plen_reg;

    logic        out_ready;
    logic        advance;
    logic        is_last;

    assign out_ready = !out_valid_reg || pop;
    assign advance   = q_valid && out_ready;
    assign is_last   = idx_reg == q_run.last_idx;
    assign q_pop     = advance && is_last;

    assign empty         = !out_valid_reg;
    assign out_byte      = byte_reg;
    assign last_of_run   = last_reg;
    assign status        = status_reg;
    assign packet_length = plen_reg;

    always_ff @(posedge clk)
    begin
        if (advance) begin
            byte_reg   <= q_run.bytes[idx_reg];
            last_reg   <= is_last;
            status_reg <= q_run.status;
            if (q_run.status == ST_OK) begin
                plen_reg <= q_run.base + 16'(idx_reg) + 16'd1;
            end
            else begin
                plen_reg <= q_run.base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? 3'd0 : idx_reg + 3'd1;
            end
            else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (last_reg && byte_reg == 8'd0))
        else $error("error request not a single zero byte");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (idx_reg <= q_run.last_idx))
        else $error("byte index past end of run");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 3'd0) |-> q_valid)
        else $error("byte index held with no run queued");

endmodule
